### rtl/bmh_pkg.sv
`timescale 1ns / 1ps

package bmh_pkg;

	localparam int OP_W     = 2;
	localparam int VERTEX_W = 8;
	localparam int DIST_W   = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 9;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT   = 2'd0,
		OP_EXTRACT  = 2'd1,
		OP_DECREASE = 2'd2
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXT,
		S_UP,
		S_UP_CMP,
		S_DN,
		S_DN_CMP,
		S_SCAN,
		S_RESP
	} state_t;

endpackage

### rtl/bmh_if.sv
`timescale 1ns / 1ps

interface bmh_req_if;
	logic                          valid;
	logic                          ready;
	logic [bmh_pkg::OP_W-1:0]      operation;
	logic [bmh_pkg::VERTEX_W-1:0]  vertex_id;
	logic [bmh_pkg::DIST_W-1:0]    new_distance;

	modport source (output valid, output operation, output vertex_id, output new_distance,
		input ready);
	modport sink (input valid, input operation, input vertex_id, input new_distance,
		output ready);
endinterface

interface bmh_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [bmh_pkg::VERTEX_W-1:0]  out_vertex;
	logic [bmh_pkg::DIST_W-1:0]    out_distance;
	logic [bmh_pkg::STATUS_W-1:0]  status;
	logic [bmh_pkg::COUNT_W-1:0]   entry_count;

	modport source (output valid, output out_vertex, output out_distance, output status,
		output entry_count, input ready);
	modport sink (input valid, input out_vertex, input out_distance, input status,
		input entry_count, output ready);
endinterface

### rtl/bmh_store.sv
`timescale 1ns / 1ps

module bmh_store #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 40
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

### rtl/binary_min_heap_priority_queue.sv
`timescale 1ns / 1ps

// Channel | Modport | Handshake         | Payload
// req     | sink    | valid/ready       | operation, vertex_id, new_distance
// rsp     | source  | valid/ready       | out_vertex, out_distance, status, entry_count
//
// Entries sit in one two-read, one-write memory with a registered read; every heap
// level is a read, then a compare and write back. Insert climbs level by level,
// extract reads the root and the last entry and then descends, and decrease-key
// scans every entry and then climbs from the match. Each item then passes through
// the response stage, and req is ready again in the cycle after it leaves it.
// Reset clears the entry count and the handshake state; the memory is not cleared.
// The output register holds a result while rsp is stalled and a new item is taken
// meanwhile; a finished item waits in the response stage until that register frees.

module binary_min_heap_priority_queue #(
	parameter int CAPACITY = 256,
	parameter int KEY_BITS = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	bmh_req_if.sink   req,
	bmh_rsp_if.source rsp
);

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CW    = IDX_W + 2;
	localparam int VW    = bmh_pkg::VERTEX_W;
	localparam int ENT_W = KEY_BITS + VW;

	bmh_pkg::state_t  state_q, state_d;
	logic [CNT_W-1:0] size_q, size_d;
	logic [CNT_W-1:0] scan_q, scan_d;
	logic             found_q, found_d;
	logic             cmpv_q, cmpv_d;
	logic             ovalid_q;

	logic [IDX_W-1:0]    pos_q, pos_d;
	logic [IDX_W-1:0]    fpos_q, fpos_d;
	logic [IDX_W-1:0]    cidx_q, cidx_d;
	logic [KEY_BITS-1:0] mkey_q, mkey_d;
	logic [VW-1:0]       mvert_q, mvert_d;
	logic [VW-1:0]       rvert_q, rvert_d;
	logic [bmh_pkg::DIST_W-1:0] rdist_q, rdist_d;
	bmh_pkg::status_t    rstat_q, rstat_d;

	logic [VW-1:0]                overt_q;
	logic [bmh_pkg::DIST_W-1:0]   odist_q;
	bmh_pkg::status_t             ostat_q;
	logic [bmh_pkg::COUNT_W-1:0]  ocnt_q;
	logic                         oload;

	logic             we;
	logic [IDX_W-1:0] waddr, raddr_a, raddr_b;
	logic [ENT_W-1:0] wdata, rdata_a, rdata_b;

	logic [KEY_BITS-1:0] key_a, key_b;
	logic [VW-1:0]       vert_a, vert_b;
	logic [63:0]         dist_wide;
	logic [KEY_BITS-1:0] key_in;
	logic [63:0]         rkey_wide;
	logic [31:0]         cnt_wide;
	logic [CNT_W-1:0]    size_m1;
	logic [CW-1:0]       lchild, rchild, size_x;
	logic [IDX_W-1:0]    parent;
	logic                rvalid, take_l, take_r;
	logic [KEY_BITS-1:0] best_key;

	bmh_store #(
		.DEPTH (CAPACITY),
		.WIDTH (ENT_W)
	) u_store (
		.clk     (clk),
		.we      (we),
		.waddr   (waddr),
		.wdata   (wdata),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	assign key_a  = rdata_a[KEY_BITS-1:0];
	assign vert_a = rdata_a[ENT_W-1:KEY_BITS];
	assign key_b  = rdata_b[KEY_BITS-1:0];
	assign vert_b = rdata_b[ENT_W-1:KEY_BITS];

	assign dist_wide = {32'd0, req.new_distance};
	assign key_in    = dist_wide[KEY_BITS-1:0];
	assign rkey_wide = 64'(key_a);
	assign cnt_wide  = 32'(size_q);
	assign size_m1   = size_q - CNT_W'(1);
	assign lchild    = {1'b0, pos_q, 1'b1};
	assign rchild    = lchild + CW'(1);
	assign size_x    = CW'(size_q);
	assign parent    = (pos_q - IDX_W'(1)) >> 1;
	assign rvalid    = rchild < size_x;
	assign take_l    = key_a < mkey_q;
	assign best_key  = take_l ? key_a : mkey_q;
	assign take_r    = rvalid && (key_b < best_key);

	assign req.ready = (state_q == bmh_pkg::S_IDLE);

	always_comb begin
		state_d = state_q;
		size_d  = size_q;
		scan_d  = scan_q;
		found_d = found_q;
		cmpv_d  = 1'b0;
		pos_d   = pos_q;
		fpos_d  = fpos_q;
		cidx_d  = cidx_q;
		mkey_d  = mkey_q;
		mvert_d = mvert_q;
		rvert_d = rvert_q;
		rdist_d = rdist_q;
		rstat_d = rstat_q;
		oload   = 1'b0;
		we      = 1'b0;
		waddr   = pos_q;
		wdata   = {mvert_q, mkey_q};
		raddr_a = '0;
		raddr_b = '0;

		unique case (state_q)
			bmh_pkg::S_IDLE: begin
				if (req.valid) begin
					mkey_d  = key_in;
					mvert_d = req.vertex_id;
					rvert_d = '0;
					rdist_d = '0;
					rstat_d = bmh_pkg::ST_OK;
					state_d = bmh_pkg::S_RESP;
					unique case (bmh_pkg::op_t'(req.operation))
						bmh_pkg::OP_INSERT: begin
							if (size_q == CNT_W'(CAPACITY)) begin
								rstat_d = bmh_pkg::ST_FULL;
							end else begin
								pos_d   = size_q[IDX_W-1:0];
								size_d  = size_q + CNT_W'(1);
								state_d = bmh_pkg::S_UP;
							end
						end
						bmh_pkg::OP_EXTRACT: begin
							if (size_q == '0) begin
								rstat_d = bmh_pkg::ST_EMPTY;
							end else begin
								raddr_a = '0;
								raddr_b = size_m1[IDX_W-1:0];
								state_d = bmh_pkg::S_EXT;
							end
						end
						bmh_pkg::OP_DECREASE: begin
							if (size_q == '0) begin
								rstat_d = bmh_pkg::ST_NOT_FOUND;
							end else begin
								scan_d  = '0;
								found_d = 1'b0;
								state_d = bmh_pkg::S_SCAN;
							end
						end
						default: ;
					endcase
				end
			end
			bmh_pkg::S_EXT: begin
				rvert_d = vert_a;
				rdist_d = rkey_wide[bmh_pkg::DIST_W-1:0];
				size_d  = size_m1;
				if (size_m1 == '0) begin
					state_d = bmh_pkg::S_RESP;
				end else begin
					// last entry becomes the hole's occupant at the root
					mkey_d  = key_b;
					mvert_d = vert_b;
					pos_d   = '0;
					state_d = bmh_pkg::S_DN;
				end
			end
			bmh_pkg::S_DN: begin
				if (lchild >= size_x) begin
					we      = 1'b1;
					state_d = bmh_pkg::S_RESP;
				end else begin
					raddr_a = lchild[IDX_W-1:0];
					raddr_b = rchild[IDX_W-1:0];
					state_d = bmh_pkg::S_DN_CMP;
				end
			end
			bmh_pkg::S_DN_CMP: begin
				we = 1'b1;
				priority if (take_r) begin
					wdata   = rdata_b;
					pos_d   = rchild[IDX_W-1:0];
					state_d = bmh_pkg::S_DN;
				end else if (take_l) begin
					wdata   = rdata_a;
					pos_d   = lchild[IDX_W-1:0];
					state_d = bmh_pkg::S_DN;
				end else begin
					state_d = bmh_pkg::S_RESP;
				end
			end
			bmh_pkg::S_UP: begin
				if (pos_q == '0) begin
					we      = 1'b1;
					state_d = bmh_pkg::S_RESP;
				end else begin
					raddr_a = parent;
					state_d = bmh_pkg::S_UP_CMP;
				end
			end
			bmh_pkg::S_UP_CMP: begin
				we = 1'b1;
				if (key_a > mkey_q) begin
					// pull the parent down into the hole and climb
					wdata   = rdata_a;
					pos_d   = parent;
					state_d = bmh_pkg::S_UP;
				end else begin
					state_d = bmh_pkg::S_RESP;
				end
			end
			bmh_pkg::S_SCAN: begin
				if (cmpv_q && (vert_a == mvert_q)) begin
					found_d = 1'b1;
					fpos_d  = cidx_q;
				end
				if (scan_q != size_q) begin
					raddr_a = scan_q[IDX_W-1:0];
					cidx_d  = scan_q[IDX_W-1:0];
					cmpv_d  = 1'b1;
					scan_d  = scan_q + CNT_W'(1);
				end else if (!cmpv_q) begin
					if (found_q) begin
						pos_d   = fpos_q;
						state_d = bmh_pkg::S_UP;
					end else begin
						rstat_d = bmh_pkg::ST_NOT_FOUND;
						state_d = bmh_pkg::S_RESP;
					end
				end
			end
			bmh_pkg::S_RESP: begin
				if (!ovalid_q || rsp.ready) begin
					oload   = 1'b1;
					state_d = bmh_pkg::S_IDLE;
				end
			end
			default: state_d = bmh_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= bmh_pkg::S_IDLE;
			size_q   <= '0;
			scan_q   <= '0;
			found_q  <= 1'b0;
			cmpv_q   <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			size_q  <= size_d;
			scan_q  <= scan_d;
			found_q <= found_d;
			cmpv_q  <= cmpv_d;
			if (oload) begin
				ovalid_q <= 1'b1;
			end else if (rsp.ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		pos_q   <= pos_d;
		fpos_q  <= fpos_d;
		cidx_q  <= cidx_d;
		mkey_q  <= mkey_d;
		mvert_q <= mvert_d;
		rvert_q <= rvert_d;
		rdist_q <= rdist_d;
		rstat_q <= rstat_d;
		if (oload) begin
			overt_q <= rvert_q;
			odist_q <= rdist_q;
			ostat_q <= rstat_q;
			ocnt_q  <= cnt_wide[bmh_pkg::COUNT_W-1:0];
		end
	end

	assign rsp.valid        = ovalid_q;
	assign rsp.out_vertex   = overt_q;
	assign rsp.out_distance = odist_q;
	assign rsp.status       = ostat_q;
	assign rsp.entry_count  = ocnt_q;

endmodule
